// File: rtl/rtp_pkg.sv
// Package for the radix integer token parser: operation codes, the queue entry
// type, the back-end status type and the character constants.
// No dependencies; every other file in rtl/ imports it.
`default_nettype none

package rtp_pkg;

  localparam int CH_W    = 8;
  localparam int VALUE_W = 63;
  localparam int DIGIT_W = 6;
  localparam int OP_W    = 2;

  // Operation codes passed from the front end to the back end.
  localparam logic [OP_W-1:0] OP_DEC_DIGIT   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_RADIX   = 2'd1;
  localparam logic [OP_W-1:0] OP_RADIX_DIGIT = 2'd2;
  localparam logic [OP_W-1:0] OP_END         = 2'd3;

  // Character codes.
  localparam logic [CH_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE     = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A     = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z     = 8'h5A;
  localparam logic [CH_W-1:0] CH_LO_A     = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z     = 8'h7A;
  localparam logic [CH_W-1:0] CH_UP_R     = 8'h52;
  localparam logic [CH_W-1:0] CH_LO_R     = 8'h72;
  localparam logic [CH_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CH_W-1:0] LETTER_MASK = 8'h1F;
  localparam logic [CH_W-1:0] LETTER_BIAS = 8'd9;

  // Largest signed 64-bit number; reaching it counts as overflow.
  localparam logic [VALUE_W-1:0] VAL_LIMIT = {VALUE_W{1'b1}};

  typedef logic [OP_W-1:0] op_code_t;

  typedef struct packed {
    op_code_t             op;
    logic [DIGIT_W-1:0]   digit;
    logic                 newline;
  } rtp_op_t;

  typedef struct packed {
    logic ready;     // back end can take the queue head this cycle
    logic mac_busy;  // back end is summing the registered products of a radix multiply-accumulate
  } rtp_back_stat_t;

endpackage

`default_nettype wire

// File: rtl/rtp_if.sv
// Channel interfaces of the radix integer token parser: the character
// channel and the result channel, each with valid/ready and its payload.
// Depends on rtp_pkg.
`default_nettype none

interface rtp_in_if import rtp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink   (input valid, input ch, input at_end, output ready);
endinterface

interface rtp_out_if import rtp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               overflow;
  logic               ended_by_newline;

  modport source (output valid, output value, output overflow,
                  output ended_by_newline, input ready);
  modport sink   (input valid, input value, input overflow,
                  input ended_by_newline, output ready);
endinterface

`default_nettype wire

// File: rtl/rtp_front.sv
// Front end of the radix integer token parser: accepts characters and turns
// each into one operation for the back end, tracking decimal/radix part.
// Depends on rtp_pkg.
`default_nettype none

module rtp_front import rtp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [CH_W-1:0] in_ch,
  input  logic            in_at_end,
  output logic            in_ready,
  input  logic            q_full,
  output logic            push,
  output rtp_op_t         entry
);

  logic mode_radix_r;
  logic mode_radix_nxt;
  logic is_dec;
  logic is_letter;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    is_dec    = in_ch inside {[CH_ZERO:CH_NINE]};
    is_letter = in_ch inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};

    entry.op      = OP_END;
    entry.digit   = DIGIT_W'(in_ch - CH_ZERO);
    entry.newline = 1'b0;

    if (in_at_end) begin
      entry.op = OP_END;
    end else if (!mode_radix_r && is_dec) begin
      entry.op = OP_DEC_DIGIT;
    end else if (!mode_radix_r && (in_ch inside {CH_UP_R, CH_LO_R})) begin
      entry.op = OP_SET_RADIX;
    end else if (mode_radix_r && is_dec) begin
      entry.op = OP_RADIX_DIGIT;
    end else if (mode_radix_r && is_letter) begin
      entry.op    = OP_RADIX_DIGIT;
      entry.digit = DIGIT_W'((in_ch & LETTER_MASK) + LETTER_BIAS);
    end else begin
      entry.op      = OP_END;
      entry.newline = (in_ch == CH_NEWLINE);
    end

    mode_radix_nxt = mode_radix_r;
    if (push) begin
      if (entry.op == OP_SET_RADIX) begin
        mode_radix_nxt = 1'b1;
      end else if (entry.op == OP_END) begin
        mode_radix_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_radix_r <= 1'b0;
    end else begin
      mode_radix_r <= mode_radix_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rtp_queue.sv
// Small first-in first-out queue of operations between the front and back
// ends of the radix integer token parser. Depends on rtp_pkg.
`default_nettype none

module rtp_queue import rtp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  rtp_op_t wr_entry,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output rtp_op_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rtp_op_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rtp_back.sv
// Back end of the radix integer token parser: multiply-accumulate with exact
// overflow test, radix capture and the registered result. Depends on rtp_pkg.
`default_nettype none

module rtp_back import rtp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  rtp_op_t            head,
  output rtp_back_stat_t     stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_overflow,
  output logic               out_newline
);

  localparam int HALF_W = 32;
  localparam int HI_W   = VALUE_W - HALF_W;
  localparam int DEC_W  = VALUE_W + 4;
  localparam int RDX_W  = 3 * HALF_W;

  logic [VALUE_W-1:0]  accum_r, accum_nxt;
  logic [VALUE_W-1:0]  base_r, base_nxt;
  logic                ovf_r, ovf_nxt;
  logic                mac_busy_r, mac_busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_ovf_r;
  logic                out_nl_r;

  logic [2*HALF_W-1:0] lo_prod_r, cross_prod_r;
  logic                both_hi_r;
  logic [DIGIT_W-1:0]  dig_r;

  logic [HI_W-1:0]     a_hi, b_hi;
  logic [HALF_W-1:0]   a_lo, b_lo, x_op, y_op;
  logic                a_hi_nz;
  logic [2*HALF_W-1:0] lo_prod, cross_prod;
  logic [DEC_W-1:0]    dec_wide, dec_sum;
  logic                dec_ovf;
  logic [RDX_W-1:0]    rdx_sum;
  logic                rdx_ovf;
  logic                out_free;
  logic                pop;

  assign a_hi    = accum_r[VALUE_W-1:HALF_W];
  assign a_lo    = accum_r[HALF_W-1:0];
  assign b_hi    = base_r[VALUE_W-1:HALF_W];
  assign b_lo    = base_r[HALF_W-1:0];
  assign a_hi_nz = (a_hi != '0);

  // When both upper halves are non-zero the product is certainly too large,
  // so only one cross term is ever needed and it shares a single multiplier.
  assign x_op       = a_hi_nz ? HALF_W'(a_hi) : a_lo;
  assign y_op       = a_hi_nz ? b_lo : HALF_W'(b_hi);
  assign lo_prod    = (2*HALF_W)'(a_lo) * (2*HALF_W)'(b_lo);
  assign cross_prod = (2*HALF_W)'(x_op) * (2*HALF_W)'(y_op);

  assign rdx_sum = {cross_prod_r, {HALF_W{1'b0}}} + RDX_W'(lo_prod_r) + RDX_W'(dig_r);
  assign rdx_ovf = both_hi_r || (rdx_sum[RDX_W-1:VALUE_W] != '0) ||
                   (rdx_sum[VALUE_W-1:0] == VAL_LIMIT);

  // Times ten as a sum of two shifts.
  assign dec_wide = DEC_W'(accum_r);
  assign dec_sum  = (dec_wide << 3) + (dec_wide << 1) + DEC_W'(head.digit);
  assign dec_ovf  = (dec_sum[DEC_W-1:VALUE_W] != '0) ||
                    (dec_sum[VALUE_W-1:0] == VAL_LIMIT);

  assign out_free   = !out_valid_r || out_ready;
  assign stat.ready = !mac_busy_r && ((head.op != OP_END) || out_free);
  assign stat.mac_busy = mac_busy_r;
  assign pop        = head_valid && stat.ready;

  always_comb begin
    accum_nxt     = accum_r;
    base_nxt      = base_r;
    ovf_nxt       = ovf_r;
    mac_busy_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    if (mac_busy_r) begin
      if (rdx_ovf) begin
        ovf_nxt   = 1'b1;
        accum_nxt = '0;
      end else begin
        accum_nxt = rdx_sum[VALUE_W-1:0];
      end
    end else if (pop) begin
      case (head.op)
        OP_DEC_DIGIT: begin
          if (dec_ovf) begin
            ovf_nxt   = 1'b1;
            accum_nxt = '0;
          end else begin
            accum_nxt = dec_sum[VALUE_W-1:0];
          end
        end
        OP_SET_RADIX: begin
          base_nxt  = accum_r;
          accum_nxt = '0;
        end
        OP_RADIX_DIGIT: begin
          mac_busy_nxt = 1'b1;
        end
        OP_END: begin
          out_valid_nxt = 1'b1;
          accum_nxt     = '0;
          base_nxt      = '0;
          ovf_nxt       = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      base_r      <= '0;
      ovf_r       <= 1'b0;
      mac_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      base_r      <= base_nxt;
      ovf_r       <= ovf_nxt;
      mac_busy_r  <= mac_busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_prod_r    <= lo_prod;
    cross_prod_r <= cross_prod;
    both_hi_r    <= a_hi_nz && (b_hi != '0);
    dig_r        <= head.digit;
    if (pop && (head.op == OP_END)) begin
      out_value_r <= ovf_r ? '0 : accum_r;
      out_ovf_r   <= ovf_r;
      out_nl_r    <= head.newline;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_overflow = out_ovf_r;
  assign out_newline  = out_nl_r;

endmodule

`default_nettype wire

// File: rtl/radix_integer_token_parser_top.sv
// Top level of the radix integer token parser: front end, operation queue
// and back end. Depends on rtp_pkg, rtp_if, rtp_front, rtp_queue, rtp_back.
//
// Usage. Characters arrive on in_chan, one per beat, with at_end marking
// the end of input. Decimal digits build a value; the first 'r' or 'R'
// makes that value the radix, after which letters and digits are digits of
// the radix part. Any other character, or at_end, closes the token and one
// result beat leaves on out_chan: the value (zero on overflow), the sticky
// overflow flag and whether the token was closed by a newline.
//
// Timing. The front end classifies a character in the cycle it is taken
// and writes an operation into a queue of QUEUE_DEPTH entries. The back end
// retires a decimal digit, a radix mark or a terminator as it pops it, and
// is busy over a radix-part digit: its 63-bit by 63-bit product uses two
// 32-bit multipliers whose outputs are registered before the sum and the
// overflow compare. Sustained rate is one beat per cycle unless that busy
// state or the receiver holds it off. A terminator passes the queue, then
// the output register holds its result. Reset clears the queue, the parse
// state and the valid flag of the output register. If the receiver holds off,
// the result waits in the output register; the queue fills, then in_chan.ready falls.
`default_nettype none

module radix_integer_token_parser_top import rtp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  rtp_in_if.sink     in_chan,
  rtp_out_if.source  out_chan
);

  rtp_op_t        f_entry;
  logic           f_push;
  logic           q_full;
  logic           q_valid;
  rtp_op_t        q_head;
  logic           q_pop;
  rtp_back_stat_t b_stat;

  // Classification of each character into an operation.
  rtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ch     (in_chan.ch),
    .in_at_end (in_chan.at_end),
    .in_ready  (in_chan.ready),
    .q_full    (q_full),
    .push      (f_push),
    .entry     (f_entry)
  );

  // The queue decouples the two ends so that each can stall on its own.
  rtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .wr_entry   (f_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  assign q_pop = q_valid && b_stat.ready;

  // Arithmetic and the result register.
  rtp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_valid),
    .head         (q_head),
    .stat         (b_stat),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_value    (out_chan.value),
    .out_overflow (out_chan.overflow),
    .out_newline  (out_chan.ended_by_newline)
  );

  // A new result only ever follows the retirement of a terminator.
  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(q_pop && (q_head.op == OP_END)))
    else $error("result raised without a terminator being retired");

  // The busy flag of a radix-part multiply-accumulate is never held: it always falls again.
  a_mac_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.mac_busy |=> !b_stat.mac_busy)
    else $error("radix multiply-accumulate held for more than two cycles");

  // A beat taken into an empty queue is at its head in the next cycle.
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && !q_valid) |=> q_valid)
    else $error("accepted beat did not reach the queue head");

endmodule

`default_nettype wire

// File: sim/radix_integer_token_parser_top_test.sv
// Self-checking bench for radix_integer_token_parser_top: it feeds character beats and checks
// every result beat against a predictor of the token parser.
// Depends on rtp_pkg, rtp_if and the RTL of the block under test.
`default_nettype none

module radix_integer_token_parser_top_test import rtp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Largest signed 64-bit number. A digit that takes the value to this or beyond overflows.
  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int PLAN_LEN = 27;
  localparam int PHASE_BEATS = 300;

  // One result beat as the parser should give it.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflow;
    logic               nl;
  } token_result_t;

  // One row of the directed table. Where pinned is set, the result is typed in by hand.
  typedef struct {
    logic [CH_W-1:0] ch;
    logic            at_end;
    bit              pinned;
    token_result_t   want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rtp_in_if  in_chan ();
  rtp_out_if out_chan ();

  radix_integer_token_parser_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #10 clk = ~clk;

  // The bench's own copy of the parse state.
  logic        st_radix_part;
  logic [63:0] st_accum;
  logic [63:0] st_radix;
  logic        st_overflowed;

  // These are the results still owed by the block, oldest first.
  token_result_t pending [$];

  int errors = 0;
  int beats_sent = 0;
  int tokens_closed = 0;
  int ovf_tokens = 0;
  int radix_tokens = 0;
  int idle_pct = 0;   // chance, in percent, that the sender idles instead of offering a beat
  int stall_pct = 0;  // chance, in percent, that the receiver stalls at each draw of ready
  int hold_left = 0;  // cycles that the receiver still holds off in a long stretch

  // This is the directed table. The pinned rows carry results that can be read straight off
  // the rules. The other rows leave the result to the predictor.
  plan_row_t plan [PLAN_LEN] = '{
    // An end mark straight after reset gives an empty token. The '5' left on ch must be ignored.
    '{8'h35, 1'b1, 1'b1, {63'd0, 1'b0, 1'b0}},
    // A newline on its own closes an empty token and flags the newline.
    '{CH_NEWLINE, 1'b0, 1'b1, {63'd0, 1'b0, 1'b1}},
    // "09" is closed by a NUL byte, which is not alphanumeric.
    '{8'h30, 1'b0, 1'b0, '0},
    '{8'h39, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, {63'd9, 1'b0, 1'b0}},
    // "Rz5": the radix mark comes with no digits before it, so the radix is zero and only the
    // last digit stays. The token is closed by byte 0xFF.
    '{CH_UP_R, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    '{8'h35, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, {63'd5, 1'b0, 1'b0}},
    // "1rabZ": with radix one the digits are summed, in both letter cases.
    '{8'h31, 1'b0, 1'b0, '0},
    '{CH_LO_R, 1'b0, 1'b0, '0},
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h62, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0},
    '{CH_NEWLINE, 1'b0, 1'b0, '0},
    // "999r" followed by seven 'z' digits runs past the limit on the last digit.
    '{8'h39, 1'b0, 1'b0, '0},
    '{8'h39, 1'b0, 1'b0, '0},
    '{8'h39, 1'b0, 1'b0, '0},
    '{CH_LO_R, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b0, '0},
    // The end mark closes the token. The newline left on ch must not set the newline flag.
    '{CH_NEWLINE, 1'b1, 1'b1, {63'd0, 1'b1, 1'b0}}
  };

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic void clear_token();
    st_radix_part = 1'b0;
    st_accum      = '0;
    st_radix      = '0;
    st_overflowed = 1'b0;
  endfunction

  // This computes accum * base + digit exactly in 128 bits. The product cannot wrap, because
  // accum and base both stay below 2^63.
  function automatic void take_digit(input logic [63:0] base, input logic [5:0] d);
    logic [127:0] full;
    full = 128'(st_accum) * 128'(base) + 128'(d);
    if (full >= 128'(I64_MAX)) begin
      st_overflowed = 1'b1;
      st_accum      = '0;
    end else begin
      st_accum = full[63:0];
    end
  endfunction

  // This advances the parse state by one character. It returns 1 when the character closes
  // the token, and res then holds the result that the block owes.
  function automatic bit parse_char(input logic [7:0] c, input logic e,
                                    output token_result_t res);
    res = '0;
    if (!e) begin
      if (!st_radix_part) begin
        if (is_dec(c)) begin
          take_digit(64'd10, 6'(c - CH_ZERO));
          return 1'b0;
        end
        if (c == CH_LO_R || c == CH_UP_R) begin
          st_radix      = st_accum;
          st_accum      = '0;
          st_radix_part = 1'b1;
          return 1'b0;
        end
      end else begin
        if (is_dec(c)) begin
          take_digit(st_radix, 6'(c - CH_ZERO));
          return 1'b0;
        end
        if (is_alpha(c)) begin
          take_digit(st_radix, 6'((c & LETTER_MASK) + LETTER_BIAS));
          return 1'b0;
        end
      end
    end
    res.value    = st_overflowed ? '0 : st_accum[VALUE_W-1:0];
    res.overflow = st_overflowed;
    res.nl       = !e && c == CH_NEWLINE;
    if (st_radix_part) radix_tokens++;
    clear_token();
    return 1'b1;
  endfunction

  // This offers one character beat and waits until the block takes it. valid stays high after
  // the handshake, so a beat that follows at once goes out with no gap. The next call, or the
  // caller, lowers valid.
  task automatic send_beat(input logic [7:0] c, input logic e, input bit pinned = 1'b0,
                           input token_result_t pinned_res = '0);
    token_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.ch     <= c;
    in_chan.at_end <= e;
    do @(posedge clk); while (!in_chan.ready);
    beats_sent++;
    if (parse_char(c, e, res)) begin
      pending.push_back(pinned ? pinned_res : res);
      tokens_closed++;
      if (res.overflow) ovf_tokens++;
    end
  endtask

  // The sender stops and waits until every result that is owed has come back. It always
  // waits on the clock before it first checks, so that valid is never lowered and raised
  // again in the same time step.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  // This builds and sends one random token. Most tokens are well formed: decimal digits,
  // an optional radix mark with digits of the radix part, then a terminator. Now and then
  // the bench sends a single stray byte instead.
  task automatic random_token();
    logic [7:0] seq [$];
    string      digits;
    int         kind;
    int         n;
    int         r;
    int         v;
    int         i;
    bit         radix_part;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_beat(8'($urandom), 1'($urandom_range(7) == 0));
      return;
    end
    radix_part = kind >= 45;
    r = 0;
    // A decimal-only token sometimes runs long enough to overflow. A radix token very now and
    // then gets a long decimal part too, so that its radix is rebuilt after an overflow.
    if (!radix_part || kind >= 95) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(24, 17) : $urandom_range(7);
      repeat (n) seq.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    if (radix_part) begin
      if (kind < 95) begin
        v = $urandom_range(99);
        if (v < 20) r = $urandom_range(2);
        else if (v < 85) r = $urandom_range(36, 2);
        else r = $urandom_range(99999, 37);
        // A radix of zero is sometimes written as nothing at all before the mark.
        digits = (r == 0 && $urandom_range(1) == 1) ? "" : $sformatf("%0d", r);
        for (i = 0; i < digits.len(); i++) seq.push_back(digits[i]);
      end
      seq.push_back($urandom_range(1) ? CH_LO_R : CH_UP_R);
      n = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(8);
      repeat (n) begin
        // Digits are mostly kept inside the radix. Any alphanumeric character is allowed too.
        if (r >= 2 && r <= 36 && $urandom_range(3) != 0) v = $urandom_range(r - 1);
        else v = $urandom_range(35);
        if (v < 10) c = CH_ZERO + 8'(v);
        else c = ($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
        seq.push_back(c);
      end
    end
    foreach (seq[k]) send_beat(seq[k], 1'b0);
    v = $urandom_range(99);
    if (v < 40) begin
      send_beat(CH_NEWLINE, 1'b0);
    end else if (v < 60) begin
      send_beat(8'($urandom), 1'b1);
    end else begin
      // Draw any byte that cannot continue the token in the part that it has reached.
      do c = 8'($urandom);
      while (is_dec(c) || (radix_part ? is_alpha(c) : (c == CH_LO_R || c == CH_UP_R)));
      send_beat(c, 1'b0);
    end
  endtask

  // The receiver stalls at random. A long hold-off, when one is asked for, takes priority.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Each result beat is compared, field by field, with the oldest result still owed.
  always @(posedge clk) begin : check_results
    token_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending.size() == 0) begin
        $display("%t: result beat with none owed: value %0d overflow %0b newline %0b",
                 $time, out_chan.value, out_chan.overflow, out_chan.ended_by_newline);
        errors++;
      end else begin
        want = pending.pop_front();
        if (out_chan.value !== want.value) begin
          $display("%t: value expected %0d, actual %0d", $time, want.value, out_chan.value);
          errors++;
        end
        if (out_chan.overflow !== want.overflow) begin
          $display("%t: overflow expected %0b, actual %0b",
                   $time, want.overflow, out_chan.overflow);
          errors++;
        end
        if (out_chan.ended_by_newline !== want.nl) begin
          $display("%t: ended_by_newline expected %0b, actual %0b",
                   $time, want.nl, out_chan.ended_by_newline);
          errors++;
        end
      end
    end
  end

  // This is the timeout. A correct run ends well before it.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int idle_set [4];
    int stall_set [4];
    int p;
    int first_beat;
    idle_set  = '{0, 88, 0, 25};
    stall_set = '{0, 0, 88, 25};
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.ch     = '0;
    in_chan.at_end = 1'b0;
    clear_token();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // First the directed table, with no idling on either side.
    foreach (plan[k]) send_beat(plan[k].ch, plan[k].at_end, plan[k].pinned, plan[k].want);

    // Then the random tokens, in four idling phases: none, a mostly idle sender, a mostly
    // stalling receiver, and light idling on both sides.
    for (p = 0; p < 4; p++) begin
      idle_pct   = idle_set[p];
      stall_pct  = stall_set[p];
      first_beat = beats_sent;
      while (beats_sent - first_beat < PHASE_BEATS) random_token();
      if (p == 0) begin
        // The receiver holds off for a long stretch while tokens keep coming. The result
        // register and the queue fill up, and the block must stall its input.
        hold_left = 80;
        repeat (12) random_token();
      end
      wait_drained();
    end

    // An end mark closes any token that a stray byte left open.
    stall_pct = 0;
    send_beat(8'($urandom), 1'b1);
    wait_drained();
    repeat (4) @(posedge clk);
    if (pending.size() != 0) begin
      $display("%t: %0d results still owed at the end", $time, pending.size());
      errors++;
    end

    $display("Sent %0d character beats that closed %0d tokens.", beats_sent, tokens_closed);
    $display("%0d tokens had a radix part and %0d overflowed. %0d check failures.",
             radix_tokens, ovf_tokens, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
